// ===== src/kvl_pkg.sv =====
// ----------------------------------------------------------------------------
// kvl_pkg
// Types and constants shared by the keyframe interpolator.
// ----------------------------------------------------------------------------
package kvl_pkg;

  localparam int unsigned VAL_W = 32;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned FRAC_W = 16;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] key_slot;
    logic [VAL_W-1:0]  key_time;
    logic [VAL_W-1:0]  key_x;
    logic [VAL_W-1:0]  key_y;
    logic [VAL_W-1:0]  key_z;
    logic [VAL_W-1:0]  query_time;
  } in_item_t;

  typedef struct packed {
    logic [VAL_W-1:0]  out_x;
    logic [VAL_W-1:0]  out_y;
    logic [VAL_W-1:0]  out_z;
    logic [SLOT_W-1:0] segment;
  } out_item_t;

  // one key as it travels down the cell row
  typedef struct packed {
    logic [VAL_W-1:0] t;
    logic [VAL_W-1:0] x;
    logic [VAL_W-1:0] y;
    logic [VAL_W-1:0] z;
  } key_t;

  // control passed from sequencer to every cell
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

// ===== src/kvl_key_cell.sv =====
// ----------------------------------------------------------------------------
// kvl_key_cell
// One table entry. Loads its key when addressed and, while the table
// rotates, takes the key of its upper neighbour, so entry 0 sees every key.
// ----------------------------------------------------------------------------
module kvl_key_cell (
  input  logic              clk,
  input  kvl_pkg::cell_ctl_t ctl,
  input  logic              sel,
  input  kvl_pkg::key_t     load_key,
  input  kvl_pkg::key_t     next_key,
  output kvl_pkg::key_t     key
);
  import kvl_pkg::*;

  key_t key_r;

  always_ff @(posedge clk) begin
    if (ctl.load && sel) begin
      key_r <= load_key;
    end else if (ctl.shift) begin
      key_r <= next_key;
    end
  end

  assign key = key_r;

endmodule

// ===== src/kvl_divider.sv =====
// ----------------------------------------------------------------------------
// kvl_divider
// Restoring divider, one quotient bit a cycle: (num << 16) / den, 16 bits.
// ----------------------------------------------------------------------------
module kvl_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [kvl_pkg::VAL_W-1:0]    num,
  input  logic [kvl_pkg::VAL_W-1:0]    den,
  output logic                         done,
  output logic [kvl_pkg::FRAC_W-1:0]   quo
);
  import kvl_pkg::*;

  logic [VAL_W:0]    rem_r, rem_nxt;
  logic [VAL_W-1:0]  den_r;
  logic [FRAC_W-1:0] quo_r, quo_nxt;
  logic [4:0]        cnt_r;
  logic              run_r, done_r;
  logic [VAL_W:0]    trial;

  // num < den holds, so the integer part is zero
  always_comb begin
    trial = {rem_r[VAL_W-1:0], 1'b0};
    rem_nxt = trial;
    quo_nxt = {quo_r[FRAC_W-2:0], 1'b0};
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      quo_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'(FRAC_W - 1)) begin
          run_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      den_r <= den;
      quo_r <= '0;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo = quo_r;

endmodule

// ===== src/keyframe_vector_lerp.sv =====
// keyframe_vector_lerp: a load item writes its key into the addressed cell and
// gives no result. A query holds busy high through rotation of the key cells (the
// search), serial division, interpolation (one 33x16 multiply per component) and
// a register for the result; the strobe follows in the next cycle. No new item is
// taken until busy falls.
// Reset (synchronous, rst_n low) idles the sequencer, sets the key count to 1, keeps keys.
// ----------------------------------------------------------------------------
// keyframe_vector_lerp
// Linear interpolation between animation keys held in a rotating cell row.
// ----------------------------------------------------------------------------
module keyframe_vector_lerp #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  kvl_pkg::in_item_t   in_item,
  output logic                out_valid,
  output kvl_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [kvl_pkg::CNT_W-1:0] cfg_data
);
  import kvl_pkg::*;

  localparam int unsigned IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned RW = $clog2(MAX_KEYS + 1);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SCAN  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_WAIT  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_ADD   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r;
  logic [RW-1:0]    step_r;
  logic [IW-1:0]    last_r;
  logic [VAL_W-1:0] qt_r;
  key_t             first_r, prev_r, seg_s_r, seg_e_r, last_key_r;
  logic [SLOT_W-1:0] seg_r;
  logic             found_r;
  logic [1:0]       comp_r;
  logic [FRAC_W-1:0] fac_r;
  logic [VAL_W-1:0] res_r [3];
  logic signed [VAL_W+FRAC_W+1:0] prod_r;
  logic             out_valid_r;
  out_item_t        out_r;

  key_t       keys [MAX_KEYS];
  cell_ctl_t  ctl;
  key_t       load_key;
  logic       div_start, div_done;
  logic [FRAC_W-1:0] div_q;
  logic [VAL_W-1:0]  off, dt;

  assign load_key = '{t: in_item.key_time, x: in_item.key_x,
                      y: in_item.key_y, z: in_item.key_z};
  assign ctl = '{load: start && !busy && in_item.mode == MODE_LOAD,
                 shift: state_r == S_SCAN};

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    kvl_key_cell u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .sel      (32'(in_item.key_slot) == g),
      .load_key (load_key),
      .next_key (keys[(g + 1) % MAX_KEYS]),
      .key      (keys[g])
    );
  end

  // entry 0 sees keys 0..MAX_KEYS-1 in order, then the row is back in place
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= CNT_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= state_r == S_OUT;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start && in_item.mode == MODE_QUERY) state_nxt = S_SCAN;
      S_SCAN: if (step_r == RW'(MAX_KEYS - 1)) state_nxt = S_DIV;
      S_DIV:  state_nxt = S_WAIT;
      S_WAIT: if (div_done) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_ADD;
      S_ADD:  state_nxt = (comp_r == 2'd2) ? S_OUT : S_MUL;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // effective last index
  always_comb begin
    if (count_r == '0) last_r = '0;
    else if (32'(count_r) > MAX_KEYS) last_r = IW'(MAX_KEYS - 1);
    else last_r = IW'(32'(count_r) - 1);
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      qt_r <= in_item.query_time;
      step_r <= '0;
      found_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      step_r <= step_r + RW'(1);
      if (step_r == '0) first_r <= keys[0];
      if (IW'(step_r) == last_r) last_key_r <= keys[0];
      prev_r <= keys[0];
      if (step_r != '0 && !found_r && IW'(step_r) <= last_r &&
          qt_r < keys[0].t) begin
        found_r <= 1'b1;
        seg_s_r <= prev_r;
        seg_e_r <= keys[0];
        seg_r <= SLOT_W'(step_r - RW'(1));
      end
    end
  end

  assign off = qt_r - seg_s_r.t;
  assign dt = seg_e_r.t - seg_s_r.t;
  assign div_start = state_r == S_DIV;

  kvl_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (off),
    .den   (dt),
    .done  (div_done),
    .quo   (div_q)
  );

  logic [VAL_W-1:0] cs, ce;
  logic signed [VAL_W:0] diff;
  always_comb begin
    case (comp_r)
      2'd0:    begin cs = seg_s_r.x; ce = seg_e_r.x; end
      2'd1:    begin cs = seg_s_r.y; ce = seg_e_r.y; end
      default: begin cs = seg_s_r.z; ce = seg_e_r.z; end
    endcase
    diff = $signed({ce[VAL_W-1], ce}) - $signed({cs[VAL_W-1], cs});
  end

  always_ff @(posedge clk) begin
    if (state_r == S_WAIT && div_done) begin
      comp_r <= '0;
      fac_r <= (qt_r >= seg_s_r.t) ? div_q : '0;
    end else if (state_r == S_MUL) begin
      prod_r <= diff * $signed({1'b0, fac_r});
    end else if (state_r == S_ADD) begin
      // arithmetic shift floors
      res_r[comp_r] <= cs + VAL_W'(prod_r >>> FRAC_W);
      comp_r <= comp_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      if (last_r == '0 || qt_r < first_r.t) begin
        out_r <= '{out_x: first_r.x, out_y: first_r.y, out_z: first_r.z,
                   segment: '0};
      end else if (qt_r >= last_key_r.t) begin
        out_r <= '{out_x: last_key_r.x, out_y: last_key_r.y,
                   out_z: last_key_r.z, segment: SLOT_W'(last_r)};
      end else begin
        out_r <= '{out_x: res_r[0], out_y: res_r[1], out_z: res_r[2],
                   segment: seg_r};
      end
    end
  end

  assign busy = state_r != S_IDLE;
  assign cfg_ready = state_r == S_IDLE;
  assign out_valid = out_valid_r;
  assign out_item = out_r;

endmodule
